### rtl/slot_table_first_free_macros.svh
// Assertion macros for the slot table block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SLOT_TABLE_FIRST_FREE_MACROS_SVH
`define SLOT_TABLE_FIRST_FREE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/sft_pkg.sv
// Shared widths, codes and control types for the slot table block.
// No dependencies; every other file but the macro header imports this package.
package sft_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 3;
    localparam int INDEX_W    = 6;
    localparam int SIZE_CFG_W = 7;
    localparam int USED_W     = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic signed [DATA_W-1:0] MARKER_RST = '0;
    localparam logic [SIZE_CFG_W-1:0]    ACTIVE_SIZE_RST = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 3'd0,
        MODE_REM_IDX = 3'd1,
        MODE_REM_VAL = 3'd2,
        MODE_QUERY   = 3'd3,
        MODE_CLEAR   = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_MARKER = 1'b0,
        CFG_ACTIVE_SIZE  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic run;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic done;
    } t_dp_sts;

endpackage

### rtl/sft_req_if.sv
// Request channel of the slot table: valid/ready plus mode, value, index.
// Depends on sft_pkg.
interface sft_req_if import sft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       index;

    modport source (output valid, output mode, output value, output index, input ready);
    modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

### rtl/sft_rsp_if.sv
// Result channel of the slot table: valid/ready plus status and aggregates.
// Depends on sft_pkg.
interface sft_rsp_if import sft_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] old_value;
    logic [USED_W-1:0]        used_count;
    logic signed [DATA_W-1:0] total;
    logic                     is_empty;
    logic                     is_full;
    logic                     any_one;
    logic                     slot_is_bit;

    modport source (output valid, output hit, output old_value, output used_count,
                    output total, output is_empty, output is_full, output any_one,
                    output slot_is_bit, input ready);
    modport sink   (input valid, input hit, input old_value, input used_count,
                    input total, input is_empty, input is_full, input any_one,
                    input slot_is_bit, output ready);
endinterface

### rtl/sft_ctrl.sv
// Sequencer of the slot table: clearing pass, scan, result hand-off.
// Depends on sft_pkg; drives the datapath through t_ctl_cmd.
module sft_ctrl import sft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  logic     i_rsp_ready,
    output logic     o_rsp_valid,
    output t_ctl_cmd o_cmd,
    input  t_dp_sts  i_sts
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.run = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.run = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_rsp_valid = o_cmd.load | (r_rsp_valid & ~i_rsp_ready);
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

### rtl/sft_dp.sv
// Datapath of the slot table: slot memory, scan counters, accumulators, result.
// Depends on sft_pkg; commanded by sft_ctrl.
module sft_dp import sft_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl_cmd                 i_cmd,
    output t_dp_sts                  o_sts,
    input  logic signed [DATA_W-1:0] i_marker,
    input  logic [$clog2(DEPTH+1)-1:0] i_size,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [INDEX_W-1:0]       i_index,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_old_value,
    output logic [USED_W-1:0]        o_used_count,
    output logic signed [DATA_W-1:0] o_total,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic                     o_any_one,
    output logic                     o_slot_is_bit
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int FW  = (CW > USED_W) ? CW : USED_W;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    logic [CW-1:0]            r_k, r_lim, r_dk;
    logic                     r_dvld, r_init;
    logic [MODE_W-1:0]        r_mode;
    logic signed [DATA_W-1:0] r_value;
    logic [INDEX_W-1:0]       r_index;

    logic                     r_found, r_one, r_bit;
    logic [USED_W-1:0]        r_used;
    logic signed [DATA_W-1:0] r_sum, r_old;

    logic                     issue, idx_ok, in_act, at_idx;
    logic                     wr, take, take_old;
    logic signed [DATA_W-1:0] m, e;

    assign issue  = i_cmd.run && (r_k < r_lim);
    assign m      = r_init ? MARKER_RST : i_marker;
    assign idx_ok = IXW'(r_index) < IXW'(i_size);
    assign in_act = r_dk < i_size;
    assign at_idx = IXW'(r_dk) == IXW'(r_index);

    assign o_sts.done = (r_k == r_lim) && !r_dvld;

    always_comb begin
        e        = r_rdata;
        wr       = 1'b0;
        take     = 1'b0;
        take_old = 1'b0;
        if (r_init) begin
            e  = m;
            wr = 1'b1;
        end else begin
            case (r_mode)
                MODE_INSERT: begin
                    if (!r_found && r_rdata == m) begin
                        e    = r_value;
                        wr   = 1'b1;
                        take = 1'b1;
                    end
                end
                MODE_REM_IDX: begin
                    if (idx_ok && at_idx) begin
                        e        = m;
                        wr       = 1'b1;
                        take_old = 1'b1;
                    end
                end
                MODE_REM_VAL: begin
                    if (!r_found && r_rdata == r_value) begin
                        e    = m;
                        wr   = 1'b1;
                        take = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    e  = m;
                    wr = 1'b1;
                end
                default: begin
                    e = r_rdata;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dvld && wr) begin
            r_mem[r_dk[AW-1:0]] <= e;
        end
        if (issue) begin
            r_rdata <= r_mem[r_k[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_lim  <= CW'(DEPTH);
            r_dvld <= 1'b0;
            r_init <= 1'b1;
        end else if (i_cmd.start) begin
            r_k    <= '0;
            r_lim  <= (i_mode == MODE_CLEAR) ? CW'(DEPTH) : i_size;
            r_dvld <= 1'b0;
            r_init <= 1'b0;
        end else begin
            r_dvld <= issue;
            if (issue) begin
                r_k <= r_k + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk <= r_k;
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_index <= i_index;
            r_found <= 1'b0;
            r_one   <= 1'b0;
            r_bit   <= 1'b0;
            r_used  <= '0;
            r_sum   <= '0;
            r_old   <= '0;
        end else if (r_dvld && !r_init) begin
            if (take) begin
                r_found <= 1'b1;
            end
            if (take_old) begin
                r_old <= r_rdata;
            end
            if (in_act) begin
                if (e != m) begin
                    r_used <= r_used + USED_W'(1);
                    r_sum  <= r_sum + e;
                end
                if (e == 32'sd1) begin
                    r_one <= 1'b1;
                end
                if (at_idx) begin
                    r_bit <= (e == 32'sd0) || (e == 32'sd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_hit         <= (r_mode == MODE_INSERT || r_mode == MODE_REM_VAL) ? r_found
                                                                               : idx_ok;
            o_old_value   <= r_old;
            o_used_count  <= r_used;
            o_total       <= r_sum;
            o_is_empty    <= (r_used == '0);
            o_is_full     <= (FW'(r_used) == FW'(i_size));
            o_any_one     <= r_one;
            o_slot_is_bit <= r_bit;
        end
    end

endmodule

### rtl/slot_table_first_free.sv
// Top level of the slot table: configuration registers, sequencer, datapath.
// Depends on sft_pkg, sft_req_if, sft_rsp_if, sft_ctrl, sft_dp and the macro header.
//
//   channel   | direction | handshake            | payload
//   i_req     | in        | valid/ready          | mode, value, index
//   o_rsp     | out       | valid/ready          | hit, old_value, used_count, total,
//             |           |                      | is_empty, is_full, any_one, slot_is_bit
//   i_cfg_*   | in        | write enable only    | i_cfg_idx, i_cfg_wdata
//
// A request scans the n active slots, n being the active size (DEPTH for clear),
// and the scan reads one slot per cycle.
// After reset a clearing pass over all DEPTH slots runs with i_req not ready;
// configuration writes are taken during it.
// The result sits in an output register; the next request is taken while it waits,
// and a finished scan holds until that register is free.
`include "slot_table_first_free_macros.svh"

module slot_table_first_free import sft_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    sft_req_if.sink              i_req,
    sft_rsp_if.source            o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > SIZE_CFG_W) ? CW : SIZE_CFG_W;

    logic signed [DATA_W-1:0] r_empty_marker;
    logic [SIZE_CFG_W-1:0]    r_active_size;
    logic [MW-1:0]            size_m;
    logic [CW-1:0]            size;
    t_ctl_cmd                 cmd;
    t_dp_sts                  sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_marker <= MARKER_RST;
            r_active_size  <= ACTIVE_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_EMPTY_MARKER: r_empty_marker <= i_cfg_wdata;
                CFG_ACTIVE_SIZE:  r_active_size  <= i_cfg_wdata[SIZE_CFG_W-1:0];
                default: begin
                    r_active_size <= r_active_size;
                end
            endcase
        end
    end

    assign size_m = (MW'(r_active_size) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(r_active_size);
    assign size   = size_m[CW-1:0];

    sft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sft_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_marker      (r_empty_marker),
        .i_size        (size),
        .i_mode        (i_req.mode),
        .i_value       (i_req.value),
        .i_index       (i_req.index),
        .o_hit         (o_rsp.hit),
        .o_old_value   (o_rsp.old_value),
        .o_used_count  (o_rsp.used_count),
        .o_total       (o_rsp.total),
        .o_is_empty    (o_rsp.is_empty),
        .o_is_full     (o_rsp.is_full),
        .o_any_one     (o_rsp.any_one),
        .o_slot_is_bit (o_rsp.slot_is_bit)
    );

    `SFT_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req.valid && i_req.ready,
                    !i_req.ready, "request taken while a scan is open")
    `SFT_ASSERT_IMP(a_rsp_from_scan, i_clk, i_rst_n, $rose(o_rsp.valid),
                    !$past(i_req.ready), "result loaded outside a finished scan")
    `SFT_ASSERT_IMP(a_old_needs_hit, i_clk, i_rst_n, o_rsp.valid && (o_rsp.old_value != 0),
                    o_rsp.hit, "old value reported without a hit")
    `SFT_ASSERT_IMP(a_empty_sum, i_clk, i_rst_n, o_rsp.valid && o_rsp.is_empty,
                    o_rsp.total == 0, "empty table with nonzero total")

endmodule

### test/slot_table_first_free_chk.sv
`timescale 1ns / 1ps
// Checker for the slot table: keeps a mirror of the table from the observed
// register writes and accepted requests, and compares every accepted result in order.
// Depends on sft_pkg, sft_req_if and sft_rsp_if.
module slot_table_first_free_chk import sft_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    sft_req_if                   i_req,
    sft_rsp_if                   i_rsp,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_fail_count
);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] old_value;
        logic [USED_W-1:0] used_count;
        logic [DATA_W-1:0] total;
        logic              is_empty;
        logic              is_full;
        logic              any_one;
        logic              slot_is_bit;
    } t_slot_result;

    logic [DATA_W-1:0]     slot_mirror [DEPTH_DEF];
    logic [DATA_W-1:0]     marker;
    logic [SIZE_CFG_W-1:0] size_cfg;
    t_slot_result          result_q [$];
    int                    fail_count = 0;
    int                    checked_count = 0;
    int                    pending_count = 0;

    assign o_pending    = pending_count;
    assign o_checked    = checked_count;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_slot_result apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [DATA_W-1:0] value,
                                                   input logic [INDEX_W-1:0] index);
        t_slot_result      r;
        int                n;
        int                k;
        int                used;
        logic [DATA_W-1:0] sum;
        logic              idx_ok;
        n = (int'(size_cfg) > DEPTH_DEF) ? DEPTH_DEF : int'(size_cfg);
        idx_ok = int'(index) < n;
        r = '0;
        used = 0;
        sum = '0;
        case (mode)
            MODE_INSERT: begin
                for (k = 0; k < n; k++) begin
                    if (slot_mirror[k] == marker) begin
                        slot_mirror[k] = value;
                        r.hit = 1'b1;
                        break;
                    end
                end
            end
            MODE_REM_IDX: begin
                if (idx_ok) begin
                    r.old_value = slot_mirror[index];
                    slot_mirror[index] = marker;
                    r.hit = 1'b1;
                end
            end
            MODE_REM_VAL: begin
                for (k = 0; k < n; k++) begin
                    if (slot_mirror[k] == value) begin
                        slot_mirror[k] = marker;
                        r.hit = 1'b1;
                        break;
                    end
                end
            end
            MODE_CLEAR: begin
                for (k = 0; k < DEPTH_DEF; k++) slot_mirror[k] = marker;
                r.hit = idx_ok;
            end
            default: r.hit = idx_ok;
        endcase
        for (k = 0; k < n; k++) begin
            if (slot_mirror[k] != marker) begin
                used++;
                sum += slot_mirror[k];
            end
            if (slot_mirror[k] == DATA_W'(1)) r.any_one = 1'b1;
        end
        r.used_count  = USED_W'(used);
        r.total       = sum;
        r.is_empty    = (used == 0);
        r.is_full     = (used == n);
        r.slot_is_bit = idx_ok && (slot_mirror[index] == DATA_W'(0) ||
                                   slot_mirror[index] == DATA_W'(1));
        return r;
    endfunction

    task automatic check_result(input t_slot_result got, input t_slot_result want);
        string             names [8];
        logic [DATA_W-1:0] got_f [8];
        logic [DATA_W-1:0] want_f [8];
        names  = '{"hit", "old_value", "used_count", "total",
                   "is_empty", "is_full", "any_one", "slot_is_bit"};
        got_f  = '{DATA_W'(got.hit), got.old_value, DATA_W'(got.used_count), got.total,
                   DATA_W'(got.is_empty), DATA_W'(got.is_full), DATA_W'(got.any_one),
                   DATA_W'(got.slot_is_bit)};
        want_f = '{DATA_W'(want.hit), want.old_value, DATA_W'(want.used_count), want.total,
                   DATA_W'(want.is_empty), DATA_W'(want.is_full), DATA_W'(want.any_one),
                   DATA_W'(want.slot_is_bit)};
        for (int f = 0; f < 8; f++) begin
            if (got_f[f] !== want_f[f])
                report_mismatch($sformatf("result %0d %s got %h want %h",
                                          checked_count, names[f], got_f[f], want_f[f]));
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_slot_result got;
        if (!i_rst_n) begin
            marker   = MARKER_RST;
            size_cfg = ACTIVE_SIZE_RST;
            foreach (slot_mirror[k]) slot_mirror[k] = MARKER_RST;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_EMPTY_MARKER) marker = i_cfg_wdata;
                else size_cfg = i_cfg_wdata[SIZE_CFG_W-1:0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{hit: i_rsp.hit, old_value: i_rsp.old_value,
                        used_count: i_rsp.used_count, total: i_rsp.total,
                        is_empty: i_rsp.is_empty, is_full: i_rsp.is_full,
                        any_one: i_rsp.any_one, slot_is_bit: i_rsp.slot_is_bit};
                if (result_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no request waiting",
                                              checked_count));
                else
                    check_result(got, result_q.pop_front());
                checked_count++;
            end
            if (i_req.valid && i_req.ready)
                result_q.push_back(apply_request(i_req.mode, i_req.value, i_req.index));
        end
        pending_count = result_q.size();
    end

endmodule

### test/slot_table_first_free_tb.sv
`timescale 1ns / 1ps
// Top of the slot table testbench: clock, reset, register writes, request and
// result traffic with idling and back-pressure, watchdog and verdict.
// Depends on sft_pkg, both channel interfaces, the block and its checker.
module slot_table_first_free_tb;
    import sft_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MAX       = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN       = 32'h8000_0000;
    localparam int PHASES         = 15;
    localparam int PHASE_ITEMS    = 106;
    localparam int POOL_N         = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_SIZES [PHASES] = '{64, 3, 1, 16, 5, 64, 2, 127, 8, 33,
                                            4, 64, 7, 1, 12};
    localparam logic [DATA_W-1:0] MARKER_CHOICES [5] = '{32'h0, VAL_MIN, 32'h1, VAL_MAX,
                                                         32'hffff_ffff};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_wdata;

    logic [DATA_W-1:0] cur_marker;
    int                cur_size;
    logic [DATA_W-1:0] value_pool [POOL_N];
    int                send_idle_pct;
    int                rcv_idle_pct;
    int                hold_requests = 0;
    int                sent_count = 0;
    int                settings_count = 0;
    int                stall_cycles = 0;
    int                pending_count;
    int                checked_count;
    int                fail_count;

    sft_req_if req_ch ();
    sft_rsp_if rsp_ch ();

    slot_table_first_free u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    slot_table_first_free_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", stall_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random idling, plus a long hold-off whenever one is asked for
    initial begin : result_sink
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                                input logic [INDEX_W-1:0] index);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode  = mode;
        req_ch.value = value;
        req_ch.index = index;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = which;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (which == CFG_EMPTY_MARKER) cur_marker = data;
        else cur_size = int'(data[SIZE_CFG_W-1:0]);
    endtask

    // drop valid, drain every result, then rewrite both registers
    task automatic retune_table(input logic [DATA_W-1:0] marker, input int size);
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_EMPTY_MARKER, marker);
        write_reg(CFG_ACTIVE_SIZE, DATA_W'(size));
        settings_count++;
    endtask

    initial begin : stimulus
        int                p;
        int                k;
        int                n;
        int                r;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
        logic [INDEX_W-1:0] index;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_EMPTY_MARKER;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = MODE_QUERY;
        req_ch.value  = '0;
        req_ch.index  = '0;
        cur_marker    = MARKER_RST;
        cur_size      = int'(ACTIVE_SIZE_RST);
        send_idle_pct = 8;
        rcv_idle_pct  = 88;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: marker 0, all 64 slots active
        send_request(MODE_QUERY, '0, '0);
        send_request(MODE_INSERT, VAL_MAX, '0);
        send_request(MODE_INSERT, VAL_MIN, '0);
        send_request(MODE_INSERT, 32'd1, '0);
        send_request(MODE_INSERT, 32'hffff_ffff, '0);
        send_request(MODE_INSERT, '0, '0);
        send_request(MODE_REM_VAL, 32'd1, 6'd2);
        send_request(MODE_REM_VAL, 32'd12345, 6'd1);
        send_request(MODE_REM_IDX, '0, 6'd0);
        send_request(MODE_REM_IDX, '0, 6'd63);
        send_request(MODE_SPARE_LO, '0, 6'd1);
        send_request(MODE_SPARE_HI, '0, 6'd63);
        send_request(MODE_CLEAR, '0, 6'd0);

        // four full slots: overflow, out-of-range index, remove the marker value
        retune_table(VAL_MIN, 4);
        for (k = 0; k < 4; k++) send_request(MODE_INSERT, DATA_W'(k), INDEX_W'(k));
        send_request(MODE_INSERT, 32'd9, 6'd3);
        send_request(MODE_REM_IDX, '0, 6'd5);
        send_request(MODE_QUERY, '0, 6'd63);
        send_request(MODE_REM_IDX, '0, 6'd1);
        send_request(MODE_REM_VAL, VAL_MIN, 6'd0);

        // marker moves to 1, a value that no active slot holds
        retune_table(32'd1, 4);
        send_request(MODE_QUERY, '0, 6'd1);

        // no active slots at all
        retune_table(32'd1, 0);
        send_request(MODE_INSERT, 32'd5, 6'd0);
        send_request(MODE_QUERY, '0, 6'd0);
        send_request(MODE_CLEAR, '0, 6'd0);

        for (p = 0; p < PHASES; p++) begin
            if (p == PHASES / 3) begin
                send_idle_pct = 88;
                rcv_idle_pct  = 8;
            end else if (p == 2 * PHASES / 3) begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            retune_table((p % 6 == 5) ? DATA_W'($urandom) : MARKER_CHOICES[p % 6],
                         PHASE_SIZES[p]);
            for (k = 0; k < POOL_N; k++) value_pool[k] = $urandom;
            value_pool[0] = VAL_MAX;
            value_pool[1] = VAL_MIN;
            if (p == 2 * PHASES / 3) hold_requests++;
            n = (cur_size > DEPTH_DEF) ? DEPTH_DEF : cur_size;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 40) mode = MODE_INSERT;
                else if (r < 60) mode = MODE_REM_IDX;
                else if (r < 80) mode = MODE_REM_VAL;
                else if (r < 92) mode = MODE_QUERY;
                else if (r < 95) mode = MODE_CLEAR;
                else mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
                r = $urandom_range(99);
                if (r < 35) value = DATA_W'($urandom_range(3));
                else if (r < 70) value = value_pool[$urandom_range(POOL_N - 1)];
                else if (r < 85) value = cur_marker;
                else value = $urandom;
                if ($urandom_range(99) < 75 && n > 0) index = INDEX_W'($urandom_range(n - 1));
                else index = INDEX_W'($urandom_range(DEPTH_DEF - 1));
                send_request(mode, value, index);
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d requests over %0d register settings, sizes 0 to 127,",
                 sent_count, settings_count + 1);
        $display("markers at both extremes, sender and receiver idling and a long stall; "
                 , "%0d results checked, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
